### rtl/rmv_pkg.sv
// Shared types and constants for the running mean / variance block.
`default_nettype none
package rmv_pkg;

    localparam int CHANNELS_DEF = 64;

    // Operand widths of the shared serial units.
    localparam int MUL_MCAND_W = 64;
    localparam int MUL_MPLR_W  = 32;
    localparam int MUL_PROD_W  = 80;
    localparam int DIV_DVD_W   = 80;
    localparam int DIV_DVS_W   = 48;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [5:0]         channel;
        logic [15:0]        sample_number;
    } in_word_t;

    typedef struct packed {
        logic [5:0]         channel_out;
        logic signed [31:0] mean;
        logic [47:0]        variance;
    } out_word_t;

    // Multiplier operand is left-aligned; steps = number of its bits used.
    typedef struct packed {
        logic [MUL_MCAND_W-1:0] mcand;
        logic [MUL_MPLR_W-1:0]  mplier;
        logic [5:0]             steps;
    } mul_req_t;

    // Dividend is left-aligned; steps = number of quotient bits produced.
    typedef struct packed {
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
        logic [6:0]           steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage
`default_nettype wire

### rtl/rmv_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module rmv_mul (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire rmv_pkg::mul_req_t                   req,
    output rmv_pkg::unit_stat_t                      stat,
    output logic [rmv_pkg::MUL_PROD_W-1:0]           prod
);
    logic [rmv_pkg::MUL_PROD_W-1:0]  acc_reg;
    logic [rmv_pkg::MUL_MCAND_W-1:0] mcand_reg;
    logic [rmv_pkg::MUL_MPLR_W-1:0]  mplier_reg;
    logic [5:0]                      cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [rmv_pkg::MUL_PROD_W-1:0]  addend;

    assign addend = mplier_reg[rmv_pkg::MUL_MPLR_W-1] ?
                    rmv_pkg::MUL_PROD_W'(mcand_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= '0;
            mcand_reg  <= req.mcand;
            mplier_reg <= req.mplier;
        end else if (busy_reg) begin
            acc_reg    <= {acc_reg[rmv_pkg::MUL_PROD_W-2:0], 1'b0} + addend;
            mplier_reg <= {mplier_reg[rmv_pkg::MUL_MPLR_W-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;
endmodule
`default_nettype wire

### rtl/rmv_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module rmv_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire rmv_pkg::div_req_t           req,
    output rmv_pkg::unit_stat_t              stat,
    output logic [rmv_pkg::DIV_DVD_W-1:0]    quot
);
    localparam int DW = rmv_pkg::DIV_DVD_W;
    localparam int VW = rmv_pkg::DIV_DVS_W;

    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] q_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW-1:0] rem_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            q_reg   <= {q_reg[DW-2:0], fits};
            // remainder stays below the divisor, so it fits in VW bits
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;
endmodule
`default_nettype wire

### rtl/running_mean_variance_top.sv
// Top level: per-channel running mean and sample variance.
//
//  port group   dir  handshake          word type
//  s_*          in   s_valid/s_ready    rmv_pkg::in_word_t
//  m_*          out  m_valid/m_ready    rmv_pkg::out_word_t
//
// One word at a time. Count above two: five serial multiplies of 16 or 32 steps
// and divides of 49, 64 and 80 steps, one bit per cycle. Count one: one multiply
// and one divide; count two: one more multiply; count zero or bad channel: none.
// After reset a clearing pass zeroes mean and variance memories; s_ready stays
// low meanwhile. A stalled result is held in the output register; the next word
// is accepted once the result has been loaded there.
`default_nettype none
module running_mean_variance_top #(
    parameter int CHANNELS = rmv_pkg::CHANNELS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire rmv_pkg::in_word_t  s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rmv_pkg::out_word_t      m_word
);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RD   = 12'b0000_0000_0010,
        S_MU   = 12'b0000_0000_0100,
        S_DM   = 12'b0000_0000_1000,
        S_V2   = 12'b0000_0001_0000,
        S_AM   = 12'b0000_0010_0000,
        S_AD   = 12'b0000_0100_0000,
        S_EM   = 12'b0000_1000_0000,
        S_SM   = 12'b0001_0000_0000,
        S_QM   = 12'b0010_0000_0000,
        S_BD   = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] mean_mem  [CHANNELS];
    logic [47:0] var_mem   [CHANNELS];
    logic [15:0] first_mem [CHANNELS];
    logic [31:0] mean_rd_reg;
    logic [47:0] var_rd_reg;
    logic [15:0] first_rd_reg;

    logic          clr_reg;
    logic [CW-1:0] clr_cnt_reg;

    logic signed [15:0] x_reg;
    logic [5:0]         ch_reg;
    logic [15:0]        m_reg;
    logic               inr_reg;
    logic [CW-1:0]      idx_reg;

    logic [31:0] mean_new_reg;
    logic [47:0] var_new_reg;
    logic [47:0] a_reg;
    logic [rmv_pkg::MUL_PROD_W-1:0] sqm_reg;
    logic        issued_reg;

    logic                 m_valid_reg;
    rmv_pkg::out_word_t   m_word_reg;

    rmv_pkg::mul_req_t    mul_req;
    rmv_pkg::div_req_t    div_req;
    rmv_pkg::unit_stat_t  mul_stat, div_stat;
    logic                 mul_start, div_start;
    logic [rmv_pkg::MUL_PROD_W-1:0] mul_res;
    logic [rmv_pkg::DIV_DVD_W-1:0]  div_q;

    logic        accept, out_free, fin_fire, mul_state, div_state;
    logic [15:0] mm1, mm2;
    logic        mu_neg;
    logic [31:0] mu_mag;
    logic [49:0] x_ext, p50, num50, mag50, qmag, qs50;
    logic        num_neg;
    logic [31:0] mean_clamped;
    logic [33:0] e34, ae34;
    logic [16:0] d17, ad17;
    logic [48:0] sum49;
    logic [47:0] var_sat;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE) && !clr_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign fin_fire = (state_reg == S_FIN) && out_free;

    // ---- arithmetic helpers ----
    assign mm1    = m_reg - 16'd1;
    assign mm2    = m_reg - 16'd2;
    assign mu_neg = mean_rd_reg[31];
    assign mu_mag = mu_neg ? (~mean_rd_reg + 32'd1) : mean_rd_reg;

    // num = x*2^16 + (m-1)*mu, from |mu|*(m-1) held in the multiplier
    assign x_ext   = {{18{x_reg[15]}}, x_reg, 16'b0};
    assign p50     = {2'b0, mul_res[47:0]};
    assign num50   = mu_neg ? (x_ext - p50) : (x_ext + p50);
    assign num_neg = num50[49];
    assign mag50   = num_neg ? (~num50 + 50'd1) : num50;
    assign qmag    = {1'b0, div_q[48:0]};
    assign qs50    = num_neg ? (~qmag + 50'd1) : qmag;

    always_comb begin
        if ((qs50[49:31] == '0) || (qs50[49:31] == '1)) begin
            mean_clamped = qs50[31:0];
        end else if (qs50[49]) begin
            mean_clamped = 32'h8000_0000;
        end else begin
            mean_clamped = 32'h7FFF_FFFF;
        end
    end

    assign e34  = x_ext[33:0] - {{2{mean_new_reg[31]}}, mean_new_reg};
    assign ae34 = e34[33] ? (~e34 + 34'd1) : e34;
    assign d17  = {first_rd_reg[15], first_rd_reg} - {x_reg[15], x_reg};
    assign ad17 = d17[16] ? (~d17 + 17'd1) : d17;

    assign sum49   = {1'b0, a_reg} + {1'b0, div_q[47:0]};
    assign var_sat = ((div_q[79:48] != '0) || sum49[48]) ? '1 : sum49[47:0];

    // ---- unit requests ----
    assign mul_state = (state_reg == S_MU) || (state_reg == S_V2) || (state_reg == S_AM) ||
                       (state_reg == S_EM) || (state_reg == S_SM) || (state_reg == S_QM);
    assign div_state = (state_reg == S_DM) || (state_reg == S_AD) || (state_reg == S_BD);
    assign mul_start = mul_state && !issued_reg;
    assign div_start = div_state && !issued_reg;

    always_comb begin
        mul_req = '0;
        unique case (state_reg)
            S_MU: begin
                mul_req.mcand  = 64'(mu_mag);
                mul_req.mplier = {mm1, 16'b0};
                mul_req.steps  = 6'd16;
            end
            S_V2: begin
                mul_req.mcand  = 64'(ad17[15:0]);
                mul_req.mplier = {ad17[15:0], 16'b0};
                mul_req.steps  = 6'd16;
            end
            S_AM: begin
                mul_req.mcand  = 64'(var_rd_reg);
                mul_req.mplier = {mm2, 16'b0};
                mul_req.steps  = 6'd16;
            end
            S_EM: begin
                mul_req.mcand  = 64'(ae34[31:0]);
                mul_req.mplier = ae34[31:0];
                mul_req.steps  = 6'd32;
            end
            S_SM: begin
                mul_req.mcand  = mul_res[63:0];
                mul_req.mplier = {m_reg, 16'b0};
                mul_req.steps  = 6'd16;
            end
            S_QM: begin
                mul_req.mcand  = 64'(mm1);
                mul_req.mplier = {mm1, 16'b0};
                mul_req.steps  = 6'd16;
            end
            default: mul_req = '0;
        endcase
    end

    always_comb begin
        div_req = '0;
        unique case (state_reg)
            S_DM: begin
                div_req.dividend = {mag50[48:0], 31'b0};
                div_req.divisor  = 48'(m_reg);
                div_req.steps    = 7'd49;
            end
            S_AD: begin
                div_req.dividend = {mul_res[63:0], 16'b0};
                div_req.divisor  = 48'(mm1);
                div_req.steps    = 7'd64;
            end
            S_BD: begin
                div_req.dividend = sqm_reg;
                div_req.divisor  = {mul_res[31:0], 16'b0};
                div_req.steps    = 7'd80;
            end
            default: div_req = '0;
        endcase
    end

    rmv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .req     (mul_req),
        .stat    (mul_stat),
        .prod    (mul_res)
    );

    rmv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (div_req),
        .stat    (div_stat),
        .quot    (div_q)
    );

    // ---- sequencer ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_RD;
            S_RD: begin
                if (!inr_reg || (m_reg == 16'd0)) state_next = S_FIN;
                else state_next = S_MU;
            end
            S_MU: if (mul_stat.done) state_next = S_DM;
            S_DM: begin
                if (div_stat.done) begin
                    if (m_reg == 16'd1) state_next = S_FIN;
                    else if (m_reg == 16'd2) state_next = S_V2;
                    else state_next = S_AM;
                end
            end
            S_V2: if (mul_stat.done) state_next = S_FIN;
            S_AM: if (mul_stat.done) state_next = S_AD;
            S_AD: if (div_stat.done) state_next = S_EM;
            S_EM: if (mul_stat.done) state_next = S_SM;
            S_SM: if (mul_stat.done) state_next = S_QM;
            S_QM: if (mul_stat.done) state_next = S_BD;
            S_BD: if (div_stat.done) state_next = S_FIN;
            S_FIN: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end else if (mul_stat.done || div_stat.done) begin
                issued_reg <= 1'b0;
            end
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CHANNELS - 1)) clr_reg <= 1'b0;
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg   <= s_word.sample;
            ch_reg  <= s_word.channel;
            m_reg   <= s_word.sample_number;
            inr_reg <= 32'(s_word.channel) < CHANNELS;
            idx_reg <= CW'(s_word.channel);
        end
        if (state_reg == S_RD) begin
            if (!inr_reg) begin
                mean_new_reg <= '0;
                var_new_reg  <= '0;
            end else begin
                mean_new_reg <= mean_rd_reg;
                var_new_reg  <= var_rd_reg;
            end
        end
        if ((state_reg == S_DM) && div_stat.done) begin
            mean_new_reg <= mean_clamped;
            if (m_reg == 16'd1) var_new_reg <= '0;
        end
        if ((state_reg == S_V2) && mul_stat.done) begin
            var_new_reg <= {1'b0, mul_res[31:0], 15'b0};
        end
        if ((state_reg == S_AD) && div_stat.done) a_reg <= div_q[47:0];
        if ((state_reg == S_SM) && mul_stat.done) sqm_reg <= mul_res;
        if ((state_reg == S_BD) && div_stat.done) var_new_reg <= var_sat;
        if (fin_fire) begin
            m_word_reg.channel_out <= ch_reg;
            m_word_reg.mean        <= mean_new_reg;
            m_word_reg.variance    <= var_new_reg;
        end
    end

    // ---- per-channel memories ----
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mean_mem[clr_cnt_reg] <= '0;
            var_mem[clr_cnt_reg]  <= '0;
        end else if (fin_fire && inr_reg && (m_reg != 16'd0)) begin
            mean_mem[idx_reg] <= mean_new_reg;
            var_mem[idx_reg]  <= var_new_reg;
        end
        if (accept) begin
            mean_rd_reg <= mean_mem[CW'(s_word.channel)];
            var_rd_reg  <= var_mem[CW'(s_word.channel)];
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire && inr_reg && (m_reg == 16'd1)) first_mem[idx_reg] <= x_reg;
        if (accept) first_rd_reg <= first_mem[CW'(s_word.channel)];
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // ---- assertions ----
    a_clr_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !s_ready) else $error("word accepted during clearing pass");

    a_mul_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy) else $error("multiplier restarted while busy");

    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy) else $error("divider restarted while busy");

    a_fin_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |=> m_valid) else $error("finished word not presented");

endmodule
`default_nettype wire

### test/tb_running_mean_variance_top.sv
// Testbench for running_mean_variance_top: random and directed words against a predictor.
`timescale 1ns / 100ps
module tb_running_mean_variance_top;

    localparam int      NUM_RANDOM = 1000;
    localparam int      TAIL_CYCLES = 400;
    localparam longint  VAR_SAT = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        rmv_pkg::in_word_t word;
        int                gap;
        bit                drain;
    } pending_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    rmv_pkg::in_word_t  s_word = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    rmv_pkg::out_word_t m_word;

    running_mean_variance_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always #1 aclk = ~aclk;

    // predictor state
    logic signed [31:0] mean_mem [64];
    logic [47:0]        var_mem [64];
    logic [15:0]        first_mem [64];

    pending_t           pending_words [$];
    rmv_pkg::out_word_t expected_stats [$];
    int        words_sent = 0;
    int        words_taken = 0;
    int        results_seen = 0;
    int        total_words = 0;
    int        mismatches = 0;

    // stimulus bookkeeping
    int  seq_count [64];
    bit  first_seen [64];

    function automatic rmv_pkg::out_word_t update_stats(rmv_pkg::in_word_t w);
        rmv_pkg::out_word_t r;
        longint      x, num, q, d, e;
        logic [63:0] mm, old, a, ae;
        logic [127:0] numr, dvs, b, sum;
        int          ch;
        ch = w.channel;
        x = longint'(w.sample);
        mm = 64'(w.sample_number);
        r.channel_out = w.channel;
        if (mm != 0) begin
            num = x * 65536 + longint'(mm - 1) * longint'(mean_mem[ch]);
            q = num / longint'(mm);
            if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
            if (q < -64'sh8000_0000) q = -64'sh8000_0000;
            mean_mem[ch] = q[31:0];
            if (mm == 1) begin
                first_mem[ch] = w.sample;
                var_mem[ch] = '0;
            end else if (mm == 2) begin
                d = longint'($signed(first_mem[ch])) - x;
                var_mem[ch] = 48'(d * d * 32768);
            end else begin
                old = 64'(var_mem[ch]);
                a = ((mm - 2) * old) / (mm - 1);
                e = x * 65536 - q;
                ae = (e < 0) ? -e : e;
                numr = 128'(ae) * 128'(ae) * 128'(mm);
                dvs = (128'(mm - 1) * 128'(mm - 1)) << 16;
                b = 128'((numr / dvs) & 128'hFFFF_FFFF_FFFF_FFFF);
                sum = 128'(a) + b;
                var_mem[ch] = (sum > 128'(VAR_SAT)) ? 48'(VAR_SAT) : sum[47:0];
            end
        end
        r.mean = mean_mem[ch];
        r.variance = var_mem[ch];
        return r;
    endfunction

    task automatic add_word(input logic [15:0] x, input int ch, input int m, input bit drain);
        pending_t p;
        // never ask for a second sample before the first one was stored
        if (m == 2 && !first_seen[ch]) m = 3;
        if (m == 1) first_seen[ch] = 1;
        if (m != 0) seq_count[ch] = m;
        p.word.sample = x;
        p.word.channel = 6'(ch);
        p.word.sample_number = 16'(m);
        p.gap = (total_words >= 300 && total_words < 400) ? 0 : $urandom_range(0, 9);
        p.drain = drain;
        pending_words.push_back(p);
        total_words++;
    endtask

    // driver
    int       gap_left = 0;
    bit       next_valid;
    pending_t cur;
    always @(negedge aclk) begin
        if (aresetn) begin
            next_valid = s_valid;
            if (s_valid && words_taken == words_sent) next_valid = 1'b0;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0 &&
                             !(pending_words[0].drain && expected_stats.size() > 0)) begin
                    cur = pending_words.pop_front();
                    s_word <= cur.word;
                    gap_left = cur.gap;
                    words_sent++;
                    next_valid = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver back-pressure
    int stall_left = 0;
    int rx_seen = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (results_seen != rx_seen) begin
                rx_seen = results_seen;
                stall_left = (rx_seen % 250 < 60) ? 0 : $urandom_range(0, 9);
            end
            if (stall_left > 0) stall_left--;
            m_ready <= (stall_left == 0);
        end
    end

    // monitor: predict on input accept, check on result accept
    rmv_pkg::out_word_t want;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_stats.push_back(update_stats(s_word));
                words_taken++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: ch %0d mean %0d var %0d",
                                 m_word.channel_out, m_word.mean, m_word.variance);
                end else begin
                    want = expected_stats.pop_front();
                    if (m_word.channel_out !== want.channel_out || m_word.mean !== want.mean ||
                        m_word.variance !== want.variance) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp ch %0d mean %0d var %0d, ",
                                      "got ch %0d mean %0d var %0d"},
                                     want.channel_out, want.mean, want.variance,
                                     m_word.channel_out, m_word.mean, m_word.variance);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int ch, m, k;
        logic [15:0] x;
        for (int i = 0; i < 64; i++) begin
            mean_mem[i] = '0;
            var_mem[i] = '0;
            first_mem[i] = '0;
            seq_count[i] = 0;
            first_seen[i] = 0;
        end
        // directed: extremes, count zero, count one/two/many, largest count
        add_word(16'h7FFF, 0, 1, 0);
        add_word(16'h8000, 0, 2, 0);
        add_word(16'h0000, 0, 3, 0);
        add_word(16'h8000, 0, 4, 0);
        add_word(16'h7FFF, 0, 0, 0);
        add_word(16'h8000, 63, 1, 0);
        add_word(16'h8000, 63, 2, 0);
        add_word(16'h7FFF, 63, 65535, 0);
        add_word(16'h0000, 63, 0, 0);
        add_word(16'h1234, 5, 3, 0);
        add_word(16'h0000, 5, 1, 0);
        add_word(16'hFFFF, 5, 2, 0);
        add_word(16'h8000, 7, 65535, 0);
        add_word(16'h7FFF, 7, 65534, 0);
        add_word(16'h5555, 42, 0, 0);
        add_word(16'hAAAA, 21, 1, 1);
        add_word(16'h5555, 21, 2, 0);
        add_word(16'h7FFF, 21, 3, 0);
        for (int i = 0; i < NUM_RANDOM; i++) begin
            k = $urandom_range(0, 99);
            ch = (k < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
            x = 16'($urandom_range(0, 65535));
            k = $urandom_range(0, 99);
            if (k < 75) m = (seq_count[ch] >= 65535) ? 1 : seq_count[ch] + 1;
            else if (k < 85) m = $urandom_range(0, 65535);
            else if (k < 92) m = 0;
            else if (k < 95) m = $urandom_range(60000, 65535);
            else m = 1;
            add_word(x, ch, m, (i == 500 || i == 800));
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (words_taken == total_words && expected_stats.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_stats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
